### rtl/ptw_pkg.sv
// Shared types, codes and helpers for the four-level page table walker.
// No dependencies; imported by the walker top level and its checker.
`timescale 1ns / 1ps

package ptw_pkg;

    // Field widths
    localparam int unsigned VA_W    = 64;
    localparam int unsigned PA_W    = 52;
    localparam int unsigned SVA_W   = 48;
    localparam int unsigned FLAGS_W = 10;
    localparam int unsigned IDX_W   = 9;

    // Item kinds
    localparam logic ACT_START    = 1'b0;
    localparam logic ACT_RESPONSE = 1'b1;
    localparam logic KIND_READ    = 1'b0;
    localparam logic KIND_FINAL   = 1'b1;

    // Walk levels
    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    // Page size codes
    localparam logic [1:0] PSZ_NONE = 2'd0;
    localparam logic [1:0] PSZ_4K   = 2'd1;
    localparam logic [1:0] PSZ_2M   = 2'd2;
    localparam logic [1:0] PSZ_1G   = 2'd3;

    // Entry bit positions
    localparam int unsigned E_PS = 7;
    localparam int unsigned E_G  = 8;
    localparam int unsigned E_NX = 63;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NONCANON    = 3'd1,
        ST_UNSUPPORTED = 3'd2,
        ST_READ_FAIL   = 3'd3,
        ST_NOT_PRESENT = 3'd4,
        ST_UNEXPECTED  = 3'd5
    } t_status;

    // Table index of the saved address at a given level
    function automatic logic [IDX_W-1:0] level_index(input logic [SVA_W-1:0] va,
                                                     input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            LVL_PML4: idx = va[47:39];
            LVL_PDPT: idx = va[38:30];
            LVL_PD:   idx = va[29:21];
            LVL_PT:   idx = va[20:12];
            default:  idx = va[20:12];
        endcase
        return idx;
    endfunction

    // Decode the flag bits of one entry: P,W,U,PWT,PCD,A,D,large,G,NX
    function automatic logic [FLAGS_W-1:0] decode_flags(input logic [63:0] e,
                                                        input logic large_ok);
        logic [FLAGS_W-1:0] f;
        f      = '0;
        f[6:0] = e[6:0];
        f[7]   = large_ok & e[E_PS];
        f[8]   = e[E_G];
        f[9]   = e[E_NX];
        return f;
    endfunction

endpackage

### rtl/four_level_page_table_walker.sv
// Four-level page table walker: input register, one walk step, result register.
// Depends on ptw_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_ready) takes a start item (i_action = 0,
//   virtual address and root register) or an entry read response (i_action = 1,
//   entry value and read-ok bit). Every input item yields exactly one result
//   item on the output channel (o_out_valid / i_out_ready): either a read
//   request for the next table entry (o_result_kind = 0) or a final result.
//   An accepted item is held in the input register, and the step logic
//   writes its result into the result register, which drives o_out_valid.
//   Throughput is one item per cycle while i_out_ready stays high; the step
//   is a mask and bit-splice, since the index times eight lands in the zero
//   low bits of the 4KB-aligned table base.
//   Memory latency sits outside the block, between a read request and its
//   response.
//   When the receiver stalls, the result register holds and the input register
//   fills; o_in_ready drops while both are occupied and i_out_ready is low.
//   Reset (synchronous, active low) empties both registers, returns the walk to
//   idle, and clears five-level mode. A high i_cfg_we writes it at the next edge.
module four_level_page_table_walker
    import ptw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_action,
    input  logic [VA_W-1:0]   i_virtual_address,
    input  logic [63:0]       i_table_root,
    input  logic [63:0]       i_entry_value,
    input  logic              i_read_ok,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_result_kind,
    output logic [PA_W-1:0]   o_entry_address,
    output logic [1:0]        o_walk_level,
    output logic [2:0]        o_status,
    output logic [PA_W-1:0]   o_physical_address,
    output logic [1:0]        o_page_size,
    output logic [FLAGS_W-1:0] o_effective_flags
);

    // Configuration and walk state
    logic                r_five_level;
    logic                r_walk_active, n_walk_active;
    logic [1:0]          r_level, n_level;
    logic [SVA_W-1:0]    r_saved_va, n_saved_va;
    logic [2:0]          r_req, n_req;
    logic [FLAGS_W-1:0]  r_acc, n_acc;

    // Input register
    logic                r_in_valid;
    logic                r_action;
    logic [VA_W-1:0]     r_va;
    logic [63:0]         r_root;
    logic [63:0]         r_entry;
    logic                r_read_ok;

    // Result register
    logic                r_out_valid;
    logic                r_kind, n_kind;
    logic [PA_W-1:0]     r_eaddr, n_eaddr;
    logic [1:0]          r_wlevel, n_wlevel;
    t_status             r_status, n_status;
    logic [PA_W-1:0]     r_pa, n_pa;
    logic [1:0]          r_psize, n_psize;
    logic [FLAGS_W-1:0]  r_flags, n_flags;

    logic                step;
    logic                in_fire;
    logic                canon;
    logic                large_ok;
    logic                is_large;
    logic [FLAGS_W-1:0]  ent_flags;
    logic [FLAGS_W-1:0]  merged;
    logic [1:0]          next_level;

    // Handshake: step when the result register is free or being drained
    assign step       = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | step;
    assign in_fire    = i_in_valid & o_in_ready;

    // Step logic: one walk step on the registered item
    always_comb begin
        canon      = (r_va[63:47] == '0) | (r_va[63:47] == '1);
        large_ok   = (r_level == LVL_PDPT) | (r_level == LVL_PD);
        is_large   = large_ok & r_entry[E_PS];
        ent_flags  = decode_flags(r_entry, large_ok);
        next_level = r_level + 2'd1;

        n_walk_active = r_walk_active;
        n_level       = r_level;
        n_saved_va    = r_saved_va;
        n_req         = r_req;
        n_acc         = r_acc;
        merged        = '0;

        n_kind   = KIND_FINAL;
        n_eaddr  = '0;
        n_wlevel = LVL_PML4;
        n_status = ST_OK;
        n_pa     = '0;
        n_psize  = PSZ_NONE;
        n_flags  = '0;

        if (r_action == ACT_START) begin
            // Drop any walk in progress and begin a new one if the address is canonical and five-level mode is off
            n_walk_active = 1'b0;
            n_level       = LVL_PML4;
            n_req         = '1;
            n_acc         = '0;
            if (!canon) begin
                n_status = ST_NONCANON;
            end else if (r_five_level) begin
                n_status = ST_UNSUPPORTED;
            end else begin
                n_saved_va    = r_va[SVA_W-1:0];
                n_walk_active = 1'b1;
                n_kind        = KIND_READ;
                n_eaddr       = {r_root[51:12], level_index(r_va[SVA_W-1:0], LVL_PML4),
                                 3'b000};
            end
        end else if (!r_walk_active) begin
            n_status = ST_UNEXPECTED;
        end else begin
            n_wlevel = r_level;
            if (!r_read_ok) begin
                n_walk_active = 1'b0;
                n_status      = ST_READ_FAIL;
            end else if (!r_entry[0]) begin
                n_walk_active = 1'b0;
                n_status      = ST_NOT_PRESENT;
            end else begin
                // Merge flags: AND for P,W,U, OR for the rest
                n_acc  = r_acc | ent_flags;
                n_req  = r_req & ent_flags[2:0];
                merged = {n_acc[FLAGS_W-1:3], n_acc[2:0] & n_req};
                if (is_large && r_level == LVL_PDPT) begin
                    n_walk_active = 1'b0;
                    n_pa    = {r_entry[51:30], r_saved_va[29:0]};
                    n_psize = PSZ_1G;
                    n_flags = merged;
                end else if (is_large) begin
                    n_walk_active = 1'b0;
                    n_pa    = {r_entry[51:21], r_saved_va[20:0]};
                    n_psize = PSZ_2M;
                    n_flags = merged;
                end else if (r_level == LVL_PT) begin
                    n_walk_active = 1'b0;
                    n_pa    = {r_entry[51:12], r_saved_va[11:0]};
                    n_psize = PSZ_4K;
                    n_flags = merged;
                end else begin
                    // Advance to the next table
                    n_level  = next_level;
                    n_kind   = KIND_READ;
                    n_wlevel = next_level;
                    n_eaddr  = {r_entry[51:12], level_index(r_saved_va, next_level), 3'b000};
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_five_level  <= 1'b0;
            r_walk_active <= 1'b0;
            r_level       <= LVL_PML4;
            r_saved_va    <= '0;
            r_req         <= '1;
            r_acc         <= '0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_five_level <= i_cfg_wdata;
            end
            if (step) begin
                r_walk_active <= n_walk_active;
                r_level       <= n_level;
                r_saved_va    <= n_saved_va;
                r_req         <= n_req;
                r_acc         <= n_acc;
            end
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input payload: load on accept
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action  <= i_action;
            r_va      <= i_virtual_address;
            r_root    <= i_table_root;
            r_entry   <= i_entry_value;
            r_read_ok <= i_read_ok;
        end
    end

    // Result payload: load on step, hold otherwise
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_kind   <= n_kind;
            r_eaddr  <= n_eaddr;
            r_wlevel <= n_wlevel;
            r_status <= n_status;
            r_pa     <= n_pa;
            r_psize  <= n_psize;
            r_flags  <= n_flags;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_result_kind      = r_kind;
    assign o_entry_address    = r_eaddr;
    assign o_walk_level       = r_wlevel;
    assign o_status           = r_status;
    assign o_physical_address = r_pa;
    assign o_page_size        = r_psize;
    assign o_effective_flags  = r_flags;

endmodule

### rtl/ptw_checker.sv
// Port-level checks for the page table walker, bound to the top level.
// Depends on ptw_pkg and four_level_page_table_walker.
`timescale 1ns / 1ps

module ptw_checker
    import ptw_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_result_kind,
    input logic [PA_W-1:0]    o_entry_address,
    input logic [1:0]         o_walk_level,
    input logic [2:0]         o_status,
    input logic [PA_W-1:0]    o_physical_address,
    input logic [1:0]         o_page_size,
    input logic [FLAGS_W-1:0] o_effective_flags
);

    // Read requests carry no translation
    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_READ |->
            o_status == ST_OK && o_physical_address == '0 &&
            o_page_size == PSZ_NONE && o_effective_flags == '0)
        else $error("read request carries translation fields");

    // Failed walks report nothing but status and level
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_FINAL && o_status != ST_OK |->
            o_physical_address == '0 && o_page_size == PSZ_NONE &&
            o_effective_flags == '0 && o_entry_address == '0)
        else $error("failed walk carries translation fields");

    // A good translation is resolved, present, and sized to its level
    a_ok_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_FINAL && o_status == ST_OK |->
            o_effective_flags[0] && o_entry_address == '0 &&
            ((o_page_size == PSZ_1G && o_walk_level == LVL_PDPT) ||
             (o_page_size == PSZ_2M && o_walk_level == LVL_PD) ||
             (o_page_size == PSZ_4K && o_walk_level == LVL_PT)))
        else $error("translation size does not match walk level");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_result_kind) && $stable(o_entry_address) &&
            $stable(o_status) && $stable(o_physical_address))
        else $error("stalled result changed");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_result_kind      (o_result_kind),
    .o_entry_address    (o_entry_address),
    .o_walk_level       (o_walk_level),
    .o_status           (o_status),
    .o_physical_address (o_physical_address),
    .o_page_size        (o_page_size),
    .o_effective_flags  (o_effective_flags)
);

### sim/four_level_page_table_walker_test.sv
// Self-checking testbench for the four-level page table walker.
// Depends on ptw_pkg and four_level_page_table_walker; a scoreboard class predicts each result.
`timescale 1ns / 1ps

module four_level_page_table_walker_test;
    import ptw_pkg::*;

    // One input item and one result item, fields at the block's widths
    typedef struct packed {
        logic              action;
        logic [VA_W-1:0]   va;
        logic [63:0]       root;
        logic [63:0]       entry;
        logic              read_ok;
    } t_walk_item;

    typedef struct packed {
        logic               kind;
        logic [PA_W-1:0]    entry_addr;
        logic [1:0]         level;
        logic [2:0]         status;
        logic [PA_W-1:0]    pa;
        logic [1:0]         psize;
        logic [FLAGS_W-1:0] flags;
    } t_walk_result;

    // Walk predictor plus the queue of results still owed by the block
    class walk_scoreboard;
        bit                 five_level;
        bit                 walk_on;
        logic [1:0]         cur_level;
        logic [SVA_W-1:0]   saved_va;
        logic [2:0]         need_pwu;
        logic [FLAGS_W-1:0] seen_flags;
        t_walk_result       due_results[$];
        int unsigned        errors;

        function new();
            five_level = 1'b0;
            walk_on    = 1'b0;
            cur_level  = LVL_PML4;
            saved_va   = '0;
            need_pwu   = 3'b111;
            seen_flags = '0;
            errors     = 0;
        endfunction

        // Table base from a root or entry word plus the saved index times eight
        function logic [PA_W-1:0] slot_address(logic [63:0] table_word, logic [1:0] lvl);
            logic [IDX_W-1:0] idx;
            case (lvl)
                LVL_PML4: idx = saved_va[47:39];
                LVL_PDPT: idx = saved_va[38:30];
                LVL_PD:   idx = saved_va[29:21];
                default:  idx = saved_va[20:12];
            endcase
            return {table_word[51:12], 12'h000} + {40'd0, idx, 3'b000};
        endfunction

        // Advance the walk by one accepted item and return the result it causes
        function t_walk_result walk_step(t_walk_item it);
            t_walk_result       r;
            logic [FLAGS_W-1:0] f;
            logic [1:0]         lvl;
            logic               canon;
            r        = '0;
            r.kind   = KIND_FINAL;
            r.status = ST_OK;
            if (it.action == ACT_START) begin
                // a start always drops whatever walk was running
                walk_on    = 1'b0;
                cur_level  = LVL_PML4;
                need_pwu   = 3'b111;
                seen_flags = '0;
                canon = it.va[47] ? (&it.va[63:48]) : (it.va[63:48] == 16'h0000);
                if (!canon) begin
                    r.status = ST_NONCANON;
                end else if (five_level) begin
                    r.status = ST_UNSUPPORTED;
                end else begin
                    saved_va     = it.va[SVA_W-1:0];
                    walk_on      = 1'b1;
                    r.kind       = KIND_READ;
                    r.entry_addr = slot_address(it.root, LVL_PML4);
                end
                return r;
            end
            if (!walk_on) begin
                r.status = ST_UNEXPECTED;
                return r;
            end
            lvl     = cur_level;
            r.level = lvl;
            if (!it.read_ok) begin
                walk_on  = 1'b0;
                r.status = ST_READ_FAIL;
                return r;
            end
            if (!it.entry[0]) begin
                walk_on  = 1'b0;
                r.status = ST_NOT_PRESENT;
                return r;
            end
            // the large bit only counts at PDPT and PD
            f = {it.entry[E_NX], it.entry[E_G],
                 it.entry[E_PS] && (lvl == LVL_PDPT || lvl == LVL_PD), it.entry[6:0]};
            seen_flags = seen_flags | f;
            need_pwu   = need_pwu & f[2:0];
            if (lvl == LVL_PDPT && it.entry[E_PS]) begin
                r.pa    = {it.entry[51:30], saved_va[29:0]};
                r.psize = PSZ_1G;
            end else if (lvl == LVL_PD && it.entry[E_PS]) begin
                r.pa    = {it.entry[51:21], saved_va[20:0]};
                r.psize = PSZ_2M;
            end else if (lvl == LVL_PT) begin
                r.pa    = {it.entry[51:12], saved_va[11:0]};
                r.psize = PSZ_4K;
            end else begin
                cur_level    = lvl + 2'd1;
                r.kind       = KIND_READ;
                r.level      = cur_level;
                r.entry_addr = slot_address(it.entry, cur_level);
                return r;
            end
            walk_on = 1'b0;
            r.flags = {seen_flags[9:3], seen_flags[2:0] & need_pwu};
            return r;
        endfunction

        function void note_request(t_walk_item it);
            due_results.push_back(walk_step(it));
        endfunction

        function void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
            if (got_v !== want_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want_v, got_v);
            end
        endfunction

        function void check_reply(t_walk_result got);
            t_walk_result want;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                return;
            end
            want = due_results.pop_front();
            check_field("result_kind", want.kind, got.kind);
            check_field("entry_address", want.entry_addr, got.entry_addr);
            check_field("walk_level", want.level, got.level);
            check_field("status", want.status, got.status);
            check_field("physical_address", want.pa, got.pa);
            check_field("page_size", want.psize, got.psize);
            check_field("effective_flags", want.flags, got.flags);
        endfunction
    endclass

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               cfg_we     = 1'b0;
    logic               cfg_wdata  = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_action  = 1'b0;
    logic [VA_W-1:0]    in_va      = '0;
    logic [63:0]        in_root    = '0;
    logic [63:0]        in_entry   = '0;
    logic               in_read_ok = 1'b0;
    logic               out_ready  = 1'b0;
    wire                in_ready;
    wire                out_valid;
    wire                res_kind;
    wire [PA_W-1:0]     res_entry_addr;
    wire [1:0]          res_level;
    wire [2:0]          res_status;
    wire [PA_W-1:0]     res_pa;
    wire [1:0]          res_psize;
    wire [FLAGS_W-1:0]  res_flags;

    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int unsigned long_hold  = 0;

    walk_scoreboard sb = new();

    four_level_page_table_walker uut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_action           (in_action),
        .i_virtual_address  (in_va),
        .i_table_root       (in_root),
        .i_entry_value      (in_entry),
        .i_read_ok          (in_read_ok),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_result_kind      (res_kind),
        .o_entry_address    (res_entry_addr),
        .o_walk_level       (res_level),
        .o_status           (res_status),
        .o_physical_address (res_pa),
        .o_page_size        (res_psize),
        .o_effective_flags  (res_flags)
    );

    always #1 clk = ~clk;

    // Hard stop in case the block hangs
    initial begin
        #200000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Check every accepted result against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            sb.check_reply({res_kind, res_entry_addr, res_level, res_status,
                            res_pa, res_psize, res_flags});
    end

    // Receiver: random stall per result while rx_idle_on is set, plus one long hold when asked
    initial begin
        int unsigned wait_cycles;
        @(posedge clk);
        forever begin
            wait_cycles = rx_idle_on ? $urandom_range(0, 3) : 0;
            if (long_hold != 0) begin
                wait_cycles = long_hold;
                long_hold   = 0;
            end
            if (wait_cycles != 0) begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid === 1'b1 && out_ready));
        end
    end

    // Offer one item after a random gap when tx_idle_on is set and hold it until accepted
    task automatic send_item(input t_walk_item it);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_action  <= it.action;
        in_va      <= it.va;
        in_root    <= it.root;
        in_entry   <= it.entry;
        in_read_ok <= it.read_ok;
        do @(posedge clk); while (!(in_valid && in_ready === 1'b1));
        sb.note_request(it);
    endtask

    task automatic send_start(input logic [63:0] va, input logic [63:0] root);
        send_item('{action: ACT_START, va: va, root: root, entry: '0, read_ok: 1'b0});
    endtask

    task automatic send_entry(input logic [63:0] entry, input logic ok);
        send_item('{action: ACT_RESPONSE, va: '0, root: '0, entry: entry, read_ok: ok});
    endtask

    // Drain the block, then write the five-level mode bit
    task automatic write_mode(input bit mode);
        in_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.five_level = mode;
    endtask

    // Mostly well-formed walks with random content; some noise and broken walks
    function automatic t_walk_item draw_item(bit walk_on);
        t_walk_item  it;
        logic [63:0] raw;
        int unsigned pick;
        pick          = $urandom_range(0, 99);
        raw           = {$urandom, $urandom};
        it.va         = {$urandom, $urandom};
        it.root       = {$urandom, $urandom};
        it.entry      = {$urandom, $urandom};
        it.read_ok    = ($urandom_range(0, 19) != 0);
        it.entry[0]   = ($urandom_range(0, 11) != 0);
        it.entry[E_PS] = ($urandom_range(0, 3) == 0);
        if (walk_on)
            it.action = (pick < 6) ? ACT_START : ACT_RESPONSE;
        else
            it.action = (pick < 8) ? ACT_RESPONSE : ACT_START;
        // most starts carry a canonical address so the walk gets going
        if (it.action == ACT_START && $urandom_range(0, 6) != 0)
            it.va = {{16{raw[47]}}, raw[47:0]};
        return it;
    endfunction

    // Main sequence
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        write_mode(1'b0);

        // response while idle, then noncanonical forms
        send_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_start(64'h0000_8000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_start(64'hFFFF_0000_0000_0000, 64'h0);
        send_start(64'h0001_0000_0000_0000, 64'h0);
        // all-ones walk: large bit at PML4 is ignored, then a failed read
        send_start(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        // 1GB page
        send_start(64'h0, 64'h0);
        send_entry(64'h0000_0000_0000_0001, 1'b1);
        send_entry(64'h800F_FFFF_C000_0183, 1'b1);
        // 2MB page
        send_start(64'h0000_7FFF_FFFF_FFFF, 64'h0000_1234_5678_9FFF);
        send_entry(64'h8000_0001_2345_6007, 1'b1);
        send_entry(64'h0000_0002_0000_0067, 1'b1);
        send_entry(64'h000F_FFFF_FFE0_0081, 1'b1);
        // full 4KB walk, PAT bit and high ignored bits at PT
        send_start(64'hFFFF_8000_0000_1234, 64'h0000_0000_0000_A000);
        send_entry(64'h0000_0000_0001_1007, 1'b1);
        send_entry(64'h0000_0000_0002_2005, 1'b1);
        send_entry(64'h0000_0000_0003_3019, 1'b1);
        send_entry(64'h7FF0_0000_0004_41FF, 1'b1);
        // not present
        send_start(64'h0000_0000_4000_0000, 64'h0000_0000_0001_0000);
        send_entry(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
        // restart mid-walk, leave the new walk open at PD
        send_start(64'h0000_1234_5678_9ABC, 64'h000F_FFFF_FFFF_F000);
        send_start(64'hFFFF_FEDC_BA98_7654, 64'h0000_0000_0000_3000);
        send_entry(64'h0000_0000_0005_5003, 1'b1);
        send_entry(64'h0000_0000_0006_6007, 1'b1);

        // five-level mode: open walk finishes, starts are refused
        write_mode(1'b1);
        send_entry(64'h0000_0000_0007_7087, 1'b1);
        send_start(64'h0000_0000_0000_1000, 64'h0);
        send_start(64'h8000_0000_0000_0000, 64'h0);
        send_entry(64'h0000_0000_0000_0001, 1'b1);
        repeat (40) send_item(draw_item(sb.walk_on));

        // random walks with idling on both sides
        write_mode(1'b0);
        repeat (200) send_item(draw_item(sb.walk_on));

        // back to back, with one long receiver hold to fill the block
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int n = 0; n < 150; n++) begin
            if (n == 40)
                long_hold = 60;
            send_item(draw_item(sb.walk_on));
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        write_mode(1'b1);
        repeat (30) send_item(draw_item(sb.walk_on));
        write_mode(1'b0);
        repeat (130) send_item(draw_item(sb.walk_on));

        // drain and let any stray result show up
        in_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### four_level_page_table_walker.f
rtl/ptw_pkg.sv
rtl/four_level_page_table_walker.sv
rtl/ptw_checker.sv
sim/four_level_page_table_walker_test.sv
